// File: design/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg
// Shared types and constants for the quadrature position counter.
// ----------------------------------------------------------------------------
package qpc_pkg;

    localparam int PPR_W      = 14;
    localparam int GLITCH_W   = 10;
    localparam int STEP_W     = 16;
    localparam int POS_W      = 32;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PPR_W-1:0]     PPR_RESET    = 14'd1024;
    localparam logic [GLITCH_W-1:0]  GLITCH_RESET = 10'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSES_PER_REV = 1'b0,
        CFG_GLITCH_CYCLES  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOTION_NONE    = 2'd0,
        MOTION_UP      = 2'd1,
        MOTION_DOWN    = 2'd2,
        MOTION_INVALID = 2'd3
    } t_motion;

    typedef struct packed {
        logic lvl_prev;
        logic lvl_next;
    } t_lvl;

endpackage

// File: design/qpc_glitch_filter.sv
// ----------------------------------------------------------------------------
// qpc_glitch_filter
// Per-channel glitch filter: a level change is accepted after it has held
// for the configured number of samples; zero passes every sample.
// ----------------------------------------------------------------------------
module qpc_glitch_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_raw,
    input  logic [qpc_pkg::GLITCH_W-1:0]  i_glitch_cycles,
    output qpc_pkg::t_lvl                 o_lvl
);

    logic                         r_level;
    logic                         n_level;
    logic [qpc_pkg::GLITCH_W-1:0] r_timer;
    logic [qpc_pkg::GLITCH_W-1:0] n_timer;
    logic [qpc_pkg::GLITCH_W-1:0] timer_inc;

    assign timer_inc = r_timer + {{(qpc_pkg::GLITCH_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_level = r_level;
        n_timer = '0;
        if (i_glitch_cycles == '0) begin
            n_level = i_raw;
        end else if (i_raw != r_level) begin
            if (timer_inc >= i_glitch_cycles) begin
                n_level = i_raw;
            end else begin
                n_timer = timer_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_timer <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_timer <= n_timer;
        end
    end

    assign o_lvl.lvl_prev = r_level;
    assign o_lvl.lvl_next = n_level;

endmodule

// File: design/quadrature_position_counter.sv
// ----------------------------------------------------------------------------
// quadrature_position_counter
// 4x quadrature decoder with glitch filter, position, turns and step in turn.
// ----------------------------------------------------------------------------
// One encoder sample is taken per clock while the output is not stalled; its
// result appears in the output register on the next cycle, and a new sample
// is taken while that result waits as long as the output is taken in the same
// cycle. Throughput is one sample per cycle when the output is not stalled;
// the clock period is set by the filter, decode, step-in-turn compare and
// 32-bit count update that run between the state registers.
module quadrature_position_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [qpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_level_a,
    input  logic                            i_level_b,
    input  logic                            i_clear,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [qpc_pkg::POS_W-1:0] o_position,
    output logic signed [qpc_pkg::POS_W-1:0] o_turns,
    output logic [qpc_pkg::STEP_W-1:0]      o_step_in_turn,
    output logic [1:0]                      o_motion
);

    logic [qpc_pkg::PPR_W-1:0]    r_ppr;
    logic [qpc_pkg::GLITCH_W-1:0] r_glitch;

    logic                         r_out_valid;
    logic [qpc_pkg::POS_W-1:0]    r_position;
    logic [qpc_pkg::POS_W-1:0]    n_position;
    logic [qpc_pkg::POS_W-1:0]    r_turns;
    logic [qpc_pkg::POS_W-1:0]    n_turns;
    logic [qpc_pkg::STEP_W-1:0]   r_step;
    logic [qpc_pkg::STEP_W-1:0]   n_step;
    qpc_pkg::t_motion             r_motion;
    qpc_pkg::t_motion             n_motion;

    qpc_pkg::t_lvl                lvl_a;
    qpc_pkg::t_lvl                lvl_b;
    logic                         accept;
    logic                         chg_a;
    logic                         chg_b;
    logic [qpc_pkg::PPR_W-1:0]    ppr_eff;
    logic [qpc_pkg::STEP_W-1:0]   limit;
    logic [qpc_pkg::STEP_W:0]     step_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr    <= qpc_pkg::PPR_RESET;
            r_glitch <= qpc_pkg::GLITCH_RESET;
        end else if (i_cfg_we) begin
            unique case (qpc_pkg::t_cfg_idx'(i_cfg_index))
                qpc_pkg::CFG_PULSES_PER_REV: r_ppr    <= i_cfg_data[qpc_pkg::PPR_W-1:0];
                qpc_pkg::CFG_GLITCH_CYCLES:  r_glitch <= i_cfg_data[qpc_pkg::GLITCH_W-1:0];
                default: ;
            endcase
        end
    end

    qpc_glitch_filter u_filt_a (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (accept),
        .i_raw           (i_level_a),
        .i_glitch_cycles (r_glitch),
        .o_lvl           (lvl_a)
    );

    qpc_glitch_filter u_filt_b (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (accept),
        .i_raw           (i_level_b),
        .i_glitch_cycles (r_glitch),
        .o_lvl           (lvl_b)
    );

    // quadrature decode
    assign chg_a = lvl_a.lvl_next != lvl_a.lvl_prev;
    assign chg_b = lvl_b.lvl_next != lvl_b.lvl_prev;

    always_comb begin
        priority if (chg_a && chg_b) begin
            n_motion = qpc_pkg::MOTION_INVALID;
        end else if (chg_a) begin
            n_motion = (lvl_a.lvl_next != lvl_b.lvl_next) ? qpc_pkg::MOTION_UP
                                                          : qpc_pkg::MOTION_DOWN;
        end else if (chg_b) begin
            n_motion = (lvl_b.lvl_next == lvl_a.lvl_next) ? qpc_pkg::MOTION_UP
                                                          : qpc_pkg::MOTION_DOWN;
        end else begin
            n_motion = qpc_pkg::MOTION_NONE;
        end
    end

    // counts; zero pulses per rev acts as one
    assign ppr_eff  = (r_ppr == '0) ? {{(qpc_pkg::PPR_W-1){1'b0}}, 1'b1} : r_ppr;
    assign limit    = {ppr_eff, 2'b00};
    assign step_inc = {1'b0, r_step} + {{qpc_pkg::STEP_W{1'b0}}, 1'b1};

    always_comb begin
        n_position = r_position;
        n_turns    = r_turns;
        n_step     = r_step;
        if (i_clear) begin
            n_position = '0;
            n_turns    = '0;
            n_step     = '0;
        end else if (n_motion == qpc_pkg::MOTION_UP) begin
            n_position = r_position + 32'd1;
            if (step_inc >= {1'b0, limit}) begin
                n_step  = '0;
                n_turns = r_turns + 32'd1;
            end else begin
                n_step  = step_inc[qpc_pkg::STEP_W-1:0];
            end
        end else if (n_motion == qpc_pkg::MOTION_DOWN) begin
            n_position = r_position - 32'd1;
            if (r_step == '0) begin
                n_step  = limit - 16'd1;
                n_turns = r_turns - 32'd1;
            end else if (r_step >= limit) begin
                n_step  = limit - 16'd1;
            end else begin
                n_step  = r_step - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_position  <= '0;
            r_turns     <= '0;
            r_step      <= '0;
            r_motion    <= qpc_pkg::MOTION_NONE;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_position  <= n_position;
                r_turns     <= n_turns;
                r_step      <= n_step;
                r_motion    <= n_motion;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_position;
    assign o_turns        = r_turns;
    assign o_step_in_turn = r_step;
    assign o_motion       = r_motion;

endmodule

// File: design/qpc_checker.sv
// ----------------------------------------------------------------------------
// qpc_checker
// Port-level checks for the quadrature position counter.
// ----------------------------------------------------------------------------
module qpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            i_clear,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic signed [qpc_pkg::POS_W-1:0] o_position,
    input logic signed [qpc_pkg::POS_W-1:0] o_turns,
    input logic [qpc_pkg::STEP_W-1:0]      o_step_in_turn,
    input logic [1:0]                      o_motion
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_clear |=>
            o_out_valid && o_position == '0 && o_turns == '0 && o_step_in_turn == '0)
        else $error("clear did not zero the counts");

    a_still_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_clear |=>
            (o_motion != qpc_pkg::MOTION_NONE && o_motion != qpc_pkg::MOTION_INVALID)
            || o_position == $past(o_position))
        else $error("position moved without counted motion");

    a_up_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_clear |=>
            o_motion != qpc_pkg::MOTION_UP || o_position == $past(o_position) + 32'sd1)
        else $error("up motion did not add one");

endmodule

bind quadrature_position_counter qpc_checker u_qpc_checker (.*);
